// File: rtl/mtlw_pkg.sv
// shared types for the multi-task liveness watchdog
// item kinds and the request token that walks the slot chain; no dependencies
package mtlw_pkg;

  localparam int unsigned IdW      = 8;
  localparam int unsigned TickW    = 32;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned SlotW    = 3;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd2000;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_REGISTER = 2'd1,
    KIND_ALIVE    = 2'd2,
    KIND_CHECK    = 2'd3
  } kind_t;

  typedef struct packed {
    logic             vld;
    kind_t            kind;
    logic [IdW-1:0]   id;
    logic             done;
    logic             hit;
    logic [SlotW-1:0] slot;
  } token_t;

endpackage

// File: rtl/mtlw_cell.sv
// one watchdog slot: client id and last report tick
// takes the request token from its left neighbor and registers it for the right; uses mtlw_pkg
module mtlw_cell import mtlw_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [TickW-1:0]    now_tick,
  input  logic [TimeoutW-1:0] timeout_ticks,
  input  token_t              tok_in,
  output token_t              tok_out
);

  logic [IdW-1:0]   client_id, client_id_next;
  logic [TickW-1:0] last_seen, last_seen_next;
  logic [TickW-1:0] age;
  token_t           tok_next;

  always_comb begin
    age            = now_tick - last_seen;
    client_id_next = client_id;
    last_seen_next = last_seen;
    tok_next       = tok_in;
    if (tok_in.vld && !tok_in.done) begin
      case (tok_in.kind)
        KIND_REGISTER: begin
          if (client_id == '0) begin
            client_id_next = tok_in.id;
            last_seen_next = now_tick;
            tok_next.done  = 1'b1;
            tok_next.hit   = 1'b1;
            tok_next.slot  = SlotW'(IDX);
          end
        end
        KIND_ALIVE: begin
          if (client_id == tok_in.id) begin
            last_seen_next = now_tick;
            tok_next.done  = 1'b1;
            tok_next.hit   = 1'b1;
            tok_next.slot  = SlotW'(IDX);
          end
        end
        KIND_CHECK: begin
          // stale when modular age exceeds the timeout
          if (client_id != '0 && age > {{(TickW-TimeoutW){1'b0}}, timeout_ticks}) begin
            tok_next.done = 1'b1;
            tok_next.hit  = 1'b1;
            tok_next.slot = SlotW'(IDX);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      client_id   <= '0;
      last_seen   <= '0;
      tok_out.vld <= 1'b0;
    end else begin
      client_id   <= client_id_next;
      last_seen   <= last_seen_next;
      tok_out.vld <= tok_next.vld;
    end
    tok_out.kind <= tok_next.kind;
    tok_out.id   <= tok_next.id;
    tok_out.done <= tok_next.done;
    tok_out.hit  <= tok_next.hit;
    tok_out.slot <= tok_next.slot;
  end

endmodule

// File: rtl/multi_task_liveness_watchdog_core.sv
// multi-task liveness watchdog: each request is registered at launch, then in each slot cell
// as it walks the chain, then in the output register; a new beat is taken only once the
// previous request has left the chain and the skid is empty, so one request is in flight.
// rst (synchronous) empties all slots, zeroes the tick counter, sets timeout to 2000.
// top level: tick counter, timeout register, chain of mtlw_cell, output register and skid
module multi_task_liveness_watchdog_core import mtlw_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [TimeoutW-1:0] cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] task_id
  input  logic [1:0]          s_tuser,   // [1:0] kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata    // [0] accepted, [3:1] slot_index,
                                         // [4] reset_request, [5] refresh_watchdog
);

  logic [TimeoutW-1:0] timeout_ticks;
  logic [TickW-1:0]    now_tick;
  logic                busy;
  logic                hold_vld;
  logic [7:0]          hold_data;
  logic [7:0]          res_data;
  logic                in_beat;
  logic                out_free;
  token_t              tok [0:SLOTS];
  token_t              tok_launch;
  token_t              tok_end;

  assign in_beat  = s_tvalid && s_tready;
  assign s_tready = !busy && !hold_vld;
  assign out_free = !m_tvalid || m_tready;
  assign tok_end  = tok[SLOTS];

  always_comb begin
    tok_launch.vld  = in_beat;
    tok_launch.kind = kind_t'(s_tuser);
    tok_launch.id   = s_tdata;
    tok_launch.hit  = 1'b0;
    tok_launch.slot = '0;
    // ticks, and id zero on register or alive, skip every cell
    tok_launch.done = (kind_t'(s_tuser) == KIND_TICK) ||
                      (kind_t'(s_tuser) != KIND_CHECK && s_tdata == '0);
  end

  always_comb begin
    res_data = '0;
    case (tok_end.kind)
      KIND_REGISTER, KIND_ALIVE: begin
        res_data[0]   = tok_end.hit;
        res_data[3:1] = tok_end.hit ? tok_end.slot : '0;
      end
      KIND_CHECK: begin
        res_data[3:1] = tok_end.hit ? tok_end.slot : '0;
        res_data[4]   = tok_end.hit;
        res_data[5]   = !tok_end.hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TimeoutReset;
      now_tick      <= '0;
      busy          <= 1'b0;
      hold_vld      <= 1'b0;
      m_tvalid      <= 1'b0;
      tok[0].vld    <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
      if (in_beat && kind_t'(s_tuser) == KIND_TICK) begin
        now_tick <= now_tick + 1'b1;
      end
      tok[0].vld <= tok_launch.vld;
      if (in_beat) begin
        busy <= 1'b1;
      end else if (tok_end.vld) begin
        busy <= 1'b0;
      end
      // result leaves the chain into the output register, or the skid when stalled
      if (tok_end.vld) begin
        if (out_free) begin
          m_tvalid <= 1'b1;
        end else begin
          hold_vld <= 1'b1;
        end
      end else if (hold_vld && out_free) begin
        m_tvalid <= 1'b1;
        hold_vld <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    tok[0].kind <= tok_launch.kind;
    tok[0].id   <= tok_launch.id;
    tok[0].done <= tok_launch.done;
    tok[0].hit  <= tok_launch.hit;
    tok[0].slot <= tok_launch.slot;
    if (tok_end.vld) begin
      if (out_free) begin
        m_tdata <= res_data;
      end else begin
        hold_data <= res_data;
      end
    end else if (hold_vld && out_free) begin
      m_tdata <= hold_data;
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    mtlw_cell #(
      .IDX(i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .now_tick     (now_tick),
      .timeout_ticks(timeout_ticks),
      .tok_in       (tok[i]),
      .tok_out      (tok[i+1])
    );
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> busy)
    else $error("request launched but block not busy");

  a_end_while_busy: assert property (@(posedge clk) disable iff (rst)
    tok_end.vld |-> busy && !hold_vld)
    else $error("result left the chain with no request in flight");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_vld |-> m_tvalid)
    else $error("skid holds a result while the output is empty");

  a_check_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({m_tdata[0], m_tdata[4], m_tdata[5]}))
    else $error("conflicting result flags");

endmodule
